/* hw/rtl/gbs_pkg.sv */
// gbs_pkg: shared types and constants for the greedy box suppression block
// no dependencies; used by gbs_cell and greedy_box_suppression
package gbs_pkg;

  // overlap threshold register, unsigned Q0.16
  localparam int unsigned THR_W       = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd45875;  // 0.7

  // reported position of a box within its set
  localparam int unsigned INDEX_W = 13;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } gbs_state_e;

endpackage

/* hw/rtl/gbs_cell.sv */
// gbs_cell: one kept-box slot of the suppression chain
// compares the passing box with its stored box and ors the result into the flag chain
// depends on gbs_pkg
module gbs_cell #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gbs_pkg::THR_W-1:0]   thr_i,
  // box passing down the chain
  input  logic [CoordBits:0]          box_x0_i,
  input  logic [CoordBits:0]          box_y0_i,
  input  logic [CoordBits:0]          box_x1_i,
  input  logic [CoordBits:0]          box_y1_i,
  input  logic [2*CoordBits-1:0]      box_area_i,
  output logic [CoordBits:0]          box_x0_o,
  output logic [CoordBits:0]          box_y0_o,
  output logic [CoordBits:0]          box_x1_o,
  output logic [CoordBits:0]          box_y1_o,
  output logic [2*CoordBits-1:0]      box_area_o,
  // suppression flag, trailing the box so that it meets this cell's compare result for the same box
  input  logic                        sup_i,
  output logic                        sup_o,
  // store write
  input  logic                        wr_en_i,
  input  logic [CoordBits:0]          wr_x0_i,
  input  logic [CoordBits:0]          wr_y0_i,
  input  logic [CoordBits:0]          wr_x1_i,
  input  logic [CoordBits:0]          wr_y1_i,
  input  logic [2*CoordBits-1:0]      wr_area_i
);
  import gbs_pkg::*;

  localparam int unsigned EdgeW = CoordBits + 1;
  localparam int unsigned AreaW = 2 * CoordBits;
  localparam int unsigned UniW  = AreaW + 1;
  localparam int unsigned ProdW = UniW + THR_W;

  // stored kept box
  logic [EdgeW-1:0] kx0_q, ky0_q, kx1_q, ky1_q;
  logic [AreaW-1:0] karea_q;

  // forwarded box
  logic [EdgeW-1:0] fx0_q, fy0_q, fx1_q, fy1_q;
  logic [AreaW-1:0] farea_q;

  // stage 1
  logic [EdgeW-1:0]     ox0, oy0, ox1, oy1;
  logic [EdgeW-1:0]     dw_full, dh_full;
  logic [CoordBits-1:0] dw, dh;
  logic [AreaW-1:0]     inter_d, inter_q;
  logic [UniW-1:0]      base_d, base_q;

  // stage 2
  logic [UniW-1:0]  uni;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [AreaW-1:0] inter2_q;
  logic             nz_q;

  // stage 3
  logic hit;
  logic sup_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      kx0_q   <= wr_x0_i;
      ky0_q   <= wr_y0_i;
      kx1_q   <= wr_x1_i;
      ky1_q   <= wr_y1_i;
      karea_q <= wr_area_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fx0_q   <= box_x0_i;
    fy0_q   <= box_y0_i;
    fx1_q   <= box_x1_i;
    fy1_q   <= box_y1_i;
    farea_q <= box_area_i;
  end

  always_comb begin
    ox0 = (box_x0_i > kx0_q) ? box_x0_i : kx0_q;
    oy0 = (box_y0_i > ky0_q) ? box_y0_i : ky0_q;
    ox1 = (box_x1_i < kx1_q) ? box_x1_i : kx1_q;
    oy1 = (box_y1_i < ky1_q) ? box_y1_i : ky1_q;
    // empty overlap gives zero intersection
    dw_full = (ox1 > ox0) ? (ox1 - ox0) : '0;
    dh_full = (oy1 > oy0) ? (oy1 - oy0) : '0;
    // overlap is never wider than the narrower box
    dw = dw_full[CoordBits-1:0];
    dh = dh_full[CoordBits-1:0];
    inter_d = AreaW'(dw) * AreaW'(dh);
    base_d  = {1'b0, box_area_i} + {1'b0, karea_q};
  end

  assign uni    = base_q - {1'b0, inter_q};
  assign prod_d = ProdW'(thr_i) * ProdW'(uni);

  always_ff @(posedge clk_i) begin
    inter_q  <= inter_d;
    base_q   <= base_d;
    prod_q   <= prod_d;
    inter2_q <= inter_q;
    nz_q     <= (uni != '0);
  end

  // inter * 2^16 > thr * union, zero union never suppresses
  assign hit = nz_q && ({1'b0, inter2_q, {FRAC_BITS{1'b0}}} > prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sup_q <= 1'b0;
    end else begin
      sup_q <= sup_i | hit;
    end
  end

  assign box_x0_o   = fx0_q;
  assign box_y0_o   = fy0_q;
  assign box_x1_o   = fx1_q;
  assign box_y1_o   = fy1_q;
  assign box_area_o = farea_q;
  assign sup_o      = sup_q;

endmodule

/* hw/rtl/greedy_box_suppression.sv */
// greedy_box_suppression: top level, request control, kept-box counters and the cell chain
// depends on gbs_pkg and gbs_cell
//
// Usage: boxes arrive on the input channel (in_valid_i / in_ready_o) sorted by
// descending score. Each request yields one result on the output channel
// (out_valid_o / out_ready_i): keep, box_index, store_overflow, set_done.
// The kept boxes sit in a chain of MAX_KEPT cells. A new box walks down the
// chain one cell per cycle, each cell compares it in its own pipeline, and
// the flag chain is read at the cell past the last kept box. A new request is
// taken only after the last one's result is written to the output register,
// and it can be taken in the cycle after that write; the walk down the chain
// sets how long each box takes.
// A result waiting on a stalled receiver does not block the next request; the
// finished result of that request waits until the output register is free.
// A box with last_in_set clears the kept count and the box counter after its
// result. Reset empties the chain, clears the counters and loads the
// threshold with 0.7; the cell contents are not cleared. The threshold must
// be written through cfg_we_i / cfg_wdata_i only while the block is idle;
// the user keeps to this, the block itself does not enforce it.
module greedy_box_suppression #(
  parameter int unsigned MAX_KEPT   = 64,
  parameter int unsigned MAX_BOXES  = 8192,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [gbs_pkg::THR_W-1:0]     cfg_wdata_i,
  // box requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         left_x_i,
  input  logic [COORD_BITS-1:0]         top_y_i,
  input  logic [COORD_BITS-1:0]         box_width_i,
  input  logic [COORD_BITS-1:0]         box_height_i,
  input  logic                          last_in_set_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          keep_o,
  output logic [gbs_pkg::INDEX_W-1:0]   box_index_o,
  output logic                          store_overflow_o,
  output logic                          set_done_o
);
  import gbs_pkg::*;

  localparam int unsigned EdgeW  = COORD_BITS + 1;
  localparam int unsigned AreaW  = 2 * COORD_BITS;
  localparam int unsigned KcW    = $clog2(MAX_KEPT + 1);
  localparam int unsigned CycW   = $clog2(MAX_KEPT + 3);
  localparam int unsigned BcW    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  gbs_state_e state_q, state_d;

  logic [THR_W-1:0] thr_q;
  logic [KcW-1:0]   kept_cnt_q;
  logic [BcW-1:0]   box_cnt_q;
  logic [CycW-1:0]  cyc_q;
  logic             res_sup_q;

  // current box
  logic [EdgeW-1:0] cur_x0_q, cur_y0_q, cur_x1_q, cur_y1_q;
  logic [AreaW-1:0] cur_area_q;
  logic             cur_last_q;

  // output register
  logic               out_valid_q;
  logic               keep_q, ovf_q, done_q;
  logic [INDEX_W-1:0] index_q;

  // chain wiring, entry 0 is the chain input
  logic [EdgeW-1:0] ch_x0   [MAX_KEPT+1];
  logic [EdgeW-1:0] ch_y0   [MAX_KEPT+1];
  logic [EdgeW-1:0] ch_x1   [MAX_KEPT+1];
  logic [EdgeW-1:0] ch_y1   [MAX_KEPT+1];
  logic [AreaW-1:0] ch_area [MAX_KEPT+1];
  logic [MAX_KEPT:0] ch_sup;

  logic in_fire, walk_end, done_fire, out_free;
  logic res_keep, store_full, store_wr;
  logic [CycW-1:0] walk_target;
  logic [BcW+INDEX_W-1:0] box_cnt_ext;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign walk_target = CycW'(kept_cnt_q) + CycW'(2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_WALK;
      S_WALK: if (cyc_q == walk_target) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    walk_end   = 1'b0;
    done_fire  = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_WALK: walk_end   = (cyc_q == walk_target);
      S_DONE: done_fire  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_x0_q   <= {1'b0, left_x_i};
      cur_y0_q   <= {1'b0, top_y_i};
      cur_x1_q   <= {1'b0, left_x_i} + {1'b0, box_width_i};
      cur_y1_q   <= {1'b0, top_y_i} + {1'b0, box_height_i};
      cur_area_q <= AreaW'(box_width_i) * AreaW'(box_height_i);
      cur_last_q <= last_in_set_i;
    end
    if (walk_end) begin
      res_sup_q <= ch_sup[kept_cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_q <= '0;
    end else if (in_fire) begin
      cyc_q <= '0;
    end else if (state_q == S_WALK) begin
      cyc_q <= cyc_q + CycW'(1);
    end
  end

  assign res_keep   = !res_sup_q;
  assign store_full = (kept_cnt_q == KcW'(MAX_KEPT));
  assign store_wr   = done_fire && res_keep && !store_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_cnt_q <= '0;
      box_cnt_q  <= '0;
    end else if (done_fire) begin
      if (cur_last_q) begin
        kept_cnt_q <= '0;
        box_cnt_q  <= '0;
      end else begin
        if (store_wr) kept_cnt_q <= kept_cnt_q + KcW'(1);
        box_cnt_q <= (box_cnt_q == BcW'(MAX_BOXES - 1)) ? '0 : box_cnt_q + BcW'(1);
      end
    end
  end

  assign box_cnt_ext = {{INDEX_W{1'b0}}, box_cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      keep_q  <= res_keep;
      ovf_q   <= res_keep && store_full;
      done_q  <= cur_last_q;
      index_q <= box_cnt_ext[INDEX_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign keep_o           = keep_q;
  assign store_overflow_o = ovf_q;
  assign set_done_o       = done_q;
  assign box_index_o      = index_q;

  assign ch_x0[0]   = cur_x0_q;
  assign ch_y0[0]   = cur_y0_q;
  assign ch_x1[0]   = cur_x1_q;
  assign ch_y1[0]   = cur_y1_q;
  assign ch_area[0] = cur_area_q;
  assign ch_sup[0]  = 1'b0;

  for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
    gbs_cell #(
      .CoordBits(COORD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .thr_i      (thr_q),
      .box_x0_i   (ch_x0[k]),
      .box_y0_i   (ch_y0[k]),
      .box_x1_i   (ch_x1[k]),
      .box_y1_i   (ch_y1[k]),
      .box_area_i (ch_area[k]),
      .box_x0_o   (ch_x0[k+1]),
      .box_y0_o   (ch_y0[k+1]),
      .box_x1_o   (ch_x1[k+1]),
      .box_y1_o   (ch_y1[k+1]),
      .box_area_o (ch_area[k+1]),
      .sup_i      (ch_sup[k]),
      .sup_o      (ch_sup[k+1]),
      .wr_en_i    (store_wr && (kept_cnt_q == KcW'(k))),
      .wr_x0_i    (cur_x0_q),
      .wr_y0_i    (cur_y0_q),
      .wr_x1_i    (cur_x1_q),
      .wr_y1_i    (cur_y1_q),
      .wr_area_i  (cur_area_q)
    );
  end

`ifndef SYNTH
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= KcW'(MAX_KEPT))
    else $error("kept count past store size");

  a_ovf_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_overflow_o |-> keep_o)
    else $error("overflow on a suppressed box");

  a_req_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_WALK) && (cyc_q == '0))
    else $error("request did not start a walk");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result without a finished walk");

  a_store_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr && !cur_last_q |=> kept_cnt_q == $past(kept_cnt_q) + KcW'(1))
    else $error("kept count did not advance on store");
`endif

endmodule
